>>> rtl/bde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Button debounce event detector package
// Shared payload types, configuration types, register indexes and reset
// values used by the debounce event detector modules.
// ----------------------------------------------------------------------------
package bde_pkg;

	// Width of the configuration register index and data.
	localparam int CfgIndexWidth = 4;
	localparam int CfgDataWidth  = 16;

	// Configuration register indexes.
	localparam logic [CfgIndexWidth-1:0] CFG_ACTIVE_LOW      = 4'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE_TIME   = 4'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_SHORT_THRESHOLD = 4'd2;
	localparam logic [CfgIndexWidth-1:0] CFG_LONG_THRESHOLD  = 4'd3;
	localparam logic [CfgIndexWidth-1:0] CFG_VLONG_THRESHOLD = 4'd4;
	localparam logic [CfgIndexWidth-1:0] CFG_DOUBLE_INTERVAL = 4'd5;
	localparam logic [CfgIndexWidth-1:0] CFG_HOLD_INTERVAL   = 4'd6;
	localparam logic [CfgIndexWidth-1:0] CFG_HOLD_ENABLE     = 4'd7;

	// Reset values of the configuration registers.
	localparam logic        RstActiveLow      = 1'b1;
	localparam logic [15:0] RstDebounceTime   = 16'd20;
	localparam logic [15:0] RstShortThreshold = 16'd1000;
	localparam logic [15:0] RstLongThreshold  = 16'd1000;
	localparam logic [15:0] RstVlongThreshold = 16'd3000;
	localparam logic [15:0] RstDoubleInterval = 16'd300;
	localparam logic [15:0] RstHoldInterval   = 16'd500;
	localparam logic        RstHoldEnable     = 1'b0;

	// Number of presses that make a double press.
	localparam logic [1:0] DoubleCount = 2'd2;

	// One poll request.
	typedef struct packed {
		logic        pin_level;
		logic [31:0] tick_now;
	} poll_t;

	// One result request.
	typedef struct packed {
		logic pressed_event;
		logic released_event;
		logic short_press_event;
		logic long_press_event;
		logic very_long_press_event;
		logic double_press_event;
		logic hold_event;
		logic pressed_active;
		logic long_active;
		logic very_long_active;
		logic holding_active;
	} rpt_t;

	// Configuration register contents.
	typedef struct packed {
		logic        active_low;
		logic [15:0] debounce_time;
		logic [15:0] short_threshold;
		logic [15:0] long_threshold;
		logic [15:0] very_long_threshold;
		logic [15:0] double_interval;
		logic [15:0] hold_interval;
		logic        hold_enable;
	} cfg_t;

	// Returns 1 when a 32-bit elapsed time is at least a 16-bit threshold.
	function automatic logic reached(input logic [31:0] elapsed, input logic [15:0] thr);
		reached = (elapsed[31:16] != 16'd0) || (elapsed[15:0] >= thr);
	endfunction

endpackage
`default_nettype wire

>>> rtl/button_debounce_event_detector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Button debounce event detector
// Debounces polled button samples and reports press, release, short, long,
// very long, double press and hold events, one result per poll.
// ----------------------------------------------------------------------------
// Usage:
//   The poll channel (poll_valid, poll_stall, poll) carries one request per
//   poll: the raw pin level and a 32-bit millisecond timestamp. The result
//   channel (rpt_valid, rpt_stall, rpt) returns exactly one request per poll,
//   in order. A request moves at a clock edge where valid is high and stall
//   is low.
//   A poll first lands in the input register, and its result is then written
//   into the output register. Throughput is one poll per cycle while the
//   receiver does not stall. When the receiver stalls, the result stays in
//   the output register and the input register holds one more poll;
//   poll_stall rises after that. Configuration registers are written through
//   cfg_wr_en, cfg_index and cfg_wdata; the user must do so only while no
//   poll is in flight, which the block does not enforce. Unknown indexes are
//   ignored. Reset clears all state to released and loads register defaults.
// ----------------------------------------------------------------------------
module button_debounce_event_detector_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              poll_valid,
	output      logic                              poll_stall,
	input  wire bde_pkg::poll_t                    poll,
	output      logic                              rpt_valid,
	input  wire logic                              rpt_stall,
	output bde_pkg::rpt_t                          rpt,
	input  wire logic                              cfg_wr_en,
	input  wire logic [bde_pkg::CfgIndexWidth-1:0] cfg_index,
	input  wire logic [bde_pkg::CfgDataWidth-1:0]  cfg_wdata
);
	import bde_pkg::*;

	cfg_t  cfg;
	poll_t poll_s1;
	logic  valid_s1;
	rpt_t  rpt_next;
	rpt_t  rpt_s2;
	logic  valid_s2;
	logic  poll_take, advance, fire;

	// Handshake control.
	assign advance    = !valid_s2 || !rpt_stall;
	assign fire       = valid_s1 && advance;
	assign poll_stall = valid_s1 && !advance;
	assign poll_take  = poll_valid && !poll_stall;

	bde_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_take) begin
			poll_s1 <= poll;
		end
	end

	bde_event_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.poll   (poll_s1),
		.cfg    (cfg),
		.rpt    (rpt_next)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!rpt_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rpt_s2 <= rpt_next;
		end
	end

	assign rpt_valid = valid_s2;
	assign rpt       = rpt_s2;

	// Very long and long never fire on the same poll.
	a_thr_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid |-> !(rpt.long_press_event && rpt.very_long_press_event))
		else $error("long and very long events fired together");

	// A short press is only reported with its release.
	a_short_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_valid && rpt.short_press_event) |-> rpt.released_event)
		else $error("short press without release");

	// A double press is only reported with a press.
	a_double_on_press: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_valid && rpt.double_press_event) |-> rpt.pressed_event)
		else $error("double press without press");

	// A hold tick only fires while pressed and in the hold phase.
	a_hold_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_valid && rpt.hold_event) |-> (rpt.pressed_active && rpt.holding_active))
		else $error("hold tick outside a held press");

endmodule
`default_nettype wire

>>> rtl/bde_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Debounce event detector configuration registers
// Holds the eight configuration registers written through a plain write port.
// ----------------------------------------------------------------------------
module bde_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [bde_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  wire logic [bde_pkg::CfgDataWidth-1:0]    cfg_wdata,
	output bde_pkg::cfg_t                            cfg
);
	import bde_pkg::*;

	cfg_t cfg_q;

	// Register file; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low          <= RstActiveLow;
			cfg_q.debounce_time       <= RstDebounceTime;
			cfg_q.short_threshold     <= RstShortThreshold;
			cfg_q.long_threshold      <= RstLongThreshold;
			cfg_q.very_long_threshold <= RstVlongThreshold;
			cfg_q.double_interval     <= RstDoubleInterval;
			cfg_q.hold_interval       <= RstHoldInterval;
			cfg_q.hold_enable         <= RstHoldEnable;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ACTIVE_LOW:      cfg_q.active_low          <= cfg_wdata[0];
				CFG_DEBOUNCE_TIME:   cfg_q.debounce_time       <= cfg_wdata;
				CFG_SHORT_THRESHOLD: cfg_q.short_threshold     <= cfg_wdata;
				CFG_LONG_THRESHOLD:  cfg_q.long_threshold      <= cfg_wdata;
				CFG_VLONG_THRESHOLD: cfg_q.very_long_threshold <= cfg_wdata;
				CFG_DOUBLE_INTERVAL: cfg_q.double_interval     <= cfg_wdata;
				CFG_HOLD_INTERVAL:   cfg_q.hold_interval       <= cfg_wdata;
				CFG_HOLD_ENABLE:     cfg_q.hold_enable         <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> rtl/bde_event_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Debounce event detector core
// Holds the debounce and press-tracking state and computes, in one pass,
// the next state and the result for the poll held in the input register.
// ----------------------------------------------------------------------------
module bde_event_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire bde_pkg::poll_t poll,
	input  wire bde_pkg::cfg_t  cfg,
	output bde_pkg::rpt_t       rpt
);
	import bde_pkg::*;

	// Current state.
	logic        filtered_q, debouncing_q, press_q;
	logic        long_q, vlong_q, holding_q;
	logic [31:0] debounce_start_q, press_start_q, hold_last_q, last_press_q;
	logic [1:0]  counter_q;

	// Next state.
	logic        filtered_d, debouncing_d, press_d;
	logic        long_d, vlong_d, holding_d;
	logic [31:0] debounce_start_d, press_start_d, hold_last_d, last_press_d;
	logic [1:0]  counter_d;

	// Elapsed times against the stored stamps.
	logic [31:0] now, deb_elapsed, press_elapsed, hold_elapsed, gap_elapsed, dur;
	logic        raw_pressed, changed, new_press;
	logic [1:0]  counter_inc;

	assign now           = poll.tick_now;
	assign raw_pressed   = poll.pin_level ^ cfg.active_low;
	assign deb_elapsed   = now - debounce_start_q;
	assign press_elapsed = now - press_start_q;
	assign hold_elapsed  = now - hold_last_q;
	assign gap_elapsed   = now - last_press_q;
	assign counter_inc   = counter_q + 2'd1;

	// Debounce filter, press/release events and timers for one poll.
	always_comb begin
		filtered_d       = filtered_q;
		debouncing_d     = debouncing_q;
		press_d          = press_q;
		long_d           = long_q;
		vlong_d          = vlong_q;
		holding_d        = holding_q;
		debounce_start_d = debounce_start_q;
		press_start_d    = press_start_q;
		hold_last_d      = hold_last_q;
		last_press_d     = last_press_q;
		counter_d        = counter_q;
		changed          = 1'b0;
		new_press        = 1'b0;
		rpt              = '0;

		// A differing level is accepted once it has persisted long enough.
		if (raw_pressed != filtered_q) begin
			if (!debouncing_q) begin
				debouncing_d     = 1'b1;
				debounce_start_d = now;
			end else if (reached(deb_elapsed, cfg.debounce_time)) begin
				filtered_d   = raw_pressed;
				debouncing_d = 1'b0;
				changed      = 1'b1;
			end
		end else begin
			debouncing_d = 1'b0;
		end

		// Accepted press or release.
		if (changed) begin
			if (filtered_d && !press_q) begin
				new_press          = 1'b1;
				press_d            = 1'b1;
				press_start_d      = now;
				long_d             = 1'b0;
				vlong_d            = 1'b0;
				rpt.pressed_event  = 1'b1;
				if (gap_elapsed[31:16] == 16'd0 && gap_elapsed[15:0] < cfg.double_interval) begin
					if (counter_inc >= DoubleCount) begin
						rpt.double_press_event = 1'b1;
						counter_d              = 2'd0;
					end else begin
						counter_d = counter_inc;
					end
				end else begin
					counter_d = 2'd1;
				end
				last_press_d = now;
			end else if (!filtered_d && press_q) begin
				press_d            = 1'b0;
				holding_d          = 1'b0;
				rpt.released_event = 1'b1;
				if (!long_q && !vlong_q && !reached(press_elapsed, cfg.short_threshold)) begin
					rpt.short_press_event = 1'b1;
				end
			end
		end

		// A press that starts on this poll has zero duration.
		dur = new_press ? 32'd0 : press_elapsed;

		// Threshold and hold timers while pressed.
		if (press_d) begin
			if (!vlong_d && reached(dur, cfg.very_long_threshold)) begin
				vlong_d                   = 1'b1;
				rpt.very_long_press_event = 1'b1;
			end else if (!long_d && reached(dur, cfg.long_threshold)) begin
				long_d               = 1'b1;
				rpt.long_press_event = 1'b1;
			end
			if (cfg.hold_enable) begin
				if (!holding_d) begin
					if (reached(dur, cfg.hold_interval)) begin
						holding_d      = 1'b1;
						hold_last_d    = now;
						rpt.hold_event = 1'b1;
					end
				end else if (reached(hold_elapsed, cfg.hold_interval)) begin
					hold_last_d    = now;
					rpt.hold_event = 1'b1;
				end
			end
		end

		rpt.pressed_active   = press_d;
		rpt.long_active      = long_d;
		rpt.very_long_active = vlong_d;
		rpt.holding_active   = holding_d;
	end

	// State update, once per processed poll.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filtered_q       <= 1'b0;
			debouncing_q     <= 1'b0;
			press_q          <= 1'b0;
			long_q           <= 1'b0;
			vlong_q          <= 1'b0;
			holding_q        <= 1'b0;
			debounce_start_q <= '0;
			press_start_q    <= '0;
			hold_last_q      <= '0;
			last_press_q     <= '0;
			counter_q        <= '0;
		end else if (fire) begin
			filtered_q       <= filtered_d;
			debouncing_q     <= debouncing_d;
			press_q          <= press_d;
			long_q           <= long_d;
			vlong_q          <= vlong_d;
			holding_q        <= holding_d;
			debounce_start_q <= debounce_start_d;
			press_start_q    <= press_start_d;
			hold_last_q      <= hold_last_d;
			last_press_q     <= last_press_d;
			counter_q        <= counter_d;
		end
	end

endmodule
`default_nettype wire
